@@ rtl/core/bqbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bqbc_pkg
// Shared types, codes and character constants of the bracket and quote
// balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bqbc_pkg;

    localparam int CODE_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int EV_W       = 3;
    localparam int REQ_W      = 2;
    localparam int OUT_LINE_W = 16;
    localparam int ERR_W      = 16;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [EV_W-1:0]   t_ev;
    typedef logic [REQ_W-1:0]  t_req;

    // request kinds
    localparam t_req REQ_CHAR = 2'd0;
    localparam t_req REQ_EOL  = 2'd1;
    localparam t_req REQ_EOI  = 2'd2;

    // reported events
    localparam t_ev EV_NONE     = 3'd0;
    localparam t_ev EV_MISMATCH = 3'd1;
    localparam t_ev EV_EMPTY    = 3'd2;
    localparam t_ev EV_UNCLOSED = 3'd3;
    localparam t_ev EV_CORRECT  = 3'd4;
    localparam t_ev EV_OVERFLOW = 3'd5;

    // stack entry codes
    localparam t_code CODE_PAREN  = 3'd0;
    localparam t_code CODE_BRACK  = 3'd1;
    localparam t_code CODE_BRACE  = 3'd2;
    localparam t_code CODE_DQUOTE = 3'd3;
    localparam t_code CODE_SQUOTE = 3'd4;
    localparam t_code CODE_NONE   = 3'd7;

    // characters of interest
    localparam t_char CH_LPAREN   = 8'd40;
    localparam t_char CH_RPAREN   = 8'd41;
    localparam t_char CH_LBRACK   = 8'd91;
    localparam t_char CH_RBRACK   = 8'd93;
    localparam t_char CH_LBRACE   = 8'd123;
    localparam t_char CH_RBRACE   = 8'd125;
    localparam t_char CH_DQUOTE   = 8'd34;
    localparam t_char CH_SQUOTE   = 8'd39;
    localparam t_char CH_END_MARK = 8'd36;

    typedef struct packed {
        t_ev                   ev_res;
        logic [OUT_LINE_W-1:0] line_number;
        t_char                 top_char;
        t_char                 current_char;
        logic [ERR_W-1:0]      error_total;
    } t_result;

    function automatic t_char code_char(input t_code code);
        t_char c;
        unique case (code)
            CODE_PAREN:  c = CH_LPAREN;
            CODE_BRACK:  c = CH_LBRACK;
            CODE_BRACE:  c = CH_LBRACE;
            CODE_DQUOTE: c = CH_DQUOTE;
            CODE_SQUOTE: c = CH_SQUOTE;
            default:     c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bqbc_stack_mem.sv @@
// ----------------------------------------------------------------------------
// bqbc_stack_mem
// Bracket stack storage: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bqbc_stack_mem
    import bqbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  wire                           i_clk,
    input  wire                           i_wr_en,
    input  wire  [$clog2(STACK_DEPTH)-1:0] i_wr_addr,
    input  t_code                         i_wr_code,
    input  wire  [$clog2(STACK_DEPTH)-1:0] i_rd_addr_a,
    input  wire  [$clog2(STACK_DEPTH)-1:0] i_rd_addr_b,
    output t_code                         o_rd_code_a,
    output t_code                         o_rd_code_b
);

    t_code r_mem [STACK_DEPTH];
    t_code r_rd_a;
    t_code r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_code;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_code_a = r_rd_a;
    assign o_rd_code_b = r_rd_b;

endmodule

`default_nettype wire

@@ rtl/core/bqbc_engine.sv @@
// ----------------------------------------------------------------------------
// bqbc_engine
// Checker state and per-request update; top of stack held in a register,
// the two entries beneath it prefetched from the stack memory.
// ----------------------------------------------------------------------------
`default_nettype none

module bqbc_engine
    import bqbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_accept,
    input  t_req                           i_req_type,
    input  t_char                          i_ch,
    input  t_code                          i_next_code,
    input  t_code                          i_third_code,
    output logic                           o_wr_en,
    output logic [$clog2(STACK_DEPTH)-1:0] o_wr_addr,
    output t_code                          o_wr_code,
    output logic [$clog2(STACK_DEPTH)-1:0] o_rd_addr_a,
    output logic [$clog2(STACK_DEPTH)-1:0] o_rd_addr_b,
    output t_result                        o_result
);

    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int IDXW = $clog2(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    logic [SPW-1:0]       r_sp,   n_sp;
    t_code                r_top,  n_top;
    logic                 r_dq,   n_dq;
    logic                 r_sq,   n_sq;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [ERR_W-1:0]     r_err,  n_err;
    logic                 r_seen, n_seen;
    logic                 r_has,  n_has;

    logic                 sp_empty;
    logic                 sp_full;
    logic [ERR_W-1:0]     err_inc;
    logic [LINE_BITS-1:0] cur_line;

    // end of line quote drops
    logic                 pop_dq;
    logic                 pop_sq;
    logic [SPW-1:0]       sp1;
    t_code                top1;
    logic [SPW-1:0]       eol_sp;
    t_code                eol_top;

    logic                 op_push;
    logic                 op_close;
    t_code                op_code;

    t_ev                  res_ev;
    logic [LINE_BITS-1:0] res_line;
    t_char                res_top;
    t_char                res_cur;
    logic [ERR_W-1:0]     res_err;
    logic [LINE_BITS+OUT_LINE_W-1:0] line_ext;

    logic [SPW-1:0]       addr_sp;
    logic [SPW-1:0]       rd_a_full;
    logic [SPW-1:0]       rd_b_full;

    assign sp_empty = (r_sp == '0);
    assign sp_full  = (r_sp >= SP_FULL);
    assign err_inc  = (r_err == '1) ? r_err : r_err + ERR_W'(1);
    assign cur_line = r_line + LINE_BITS'(1);

    assign pop_dq  = r_dq && !sp_empty && (r_top == CODE_DQUOTE);
    assign sp1     = r_sp - SPW'(pop_dq);
    assign top1    = pop_dq ? i_next_code : r_top;
    assign pop_sq  = r_sq && (sp1 != '0) && (top1 == CODE_SQUOTE);
    assign eol_sp  = sp1 - SPW'(pop_sq);
    assign eol_top = pop_sq ? (pop_dq ? i_third_code : i_next_code) : top1;

    always_comb begin
        n_sp     = r_sp;
        n_top    = r_top;
        n_dq     = r_dq;
        n_sq     = r_sq;
        n_line   = r_line;
        n_err    = r_err;
        n_seen   = r_seen;
        n_has    = r_has;
        o_wr_en  = 1'b0;
        op_push  = 1'b0;
        op_close = 1'b0;
        op_code  = CODE_NONE;
        res_ev   = EV_NONE;
        res_line = '0;
        res_top  = '0;
        res_cur  = '0;
        res_err  = r_err;

        unique case (i_req_type)
            REQ_CHAR: begin
                n_has = 1'b1;
                unique case (i_ch)
                    CH_LPAREN: begin
                        op_push = 1'b1;
                        op_code = CODE_PAREN;
                    end
                    CH_LBRACK: begin
                        op_push = 1'b1;
                        op_code = CODE_BRACK;
                    end
                    CH_LBRACE: begin
                        op_push = 1'b1;
                        op_code = CODE_BRACE;
                    end
                    CH_RPAREN: begin
                        op_close = 1'b1;
                        op_code  = CODE_PAREN;
                    end
                    CH_RBRACK: begin
                        op_close = 1'b1;
                        op_code  = CODE_BRACK;
                    end
                    CH_RBRACE: begin
                        op_close = 1'b1;
                        op_code  = CODE_BRACE;
                    end
                    CH_DQUOTE: begin
                        n_dq     = ~r_dq;
                        op_push  = ~r_dq;
                        op_close = r_dq;
                        op_code  = CODE_DQUOTE;
                    end
                    CH_SQUOTE: begin
                        n_sq     = ~r_sq;
                        op_push  = ~r_sq;
                        op_close = r_sq;
                        op_code  = CODE_SQUOTE;
                    end
                    default: begin
                    end
                endcase

                if (op_push) begin
                    if (sp_full) begin
                        n_err    = err_inc;
                        res_err  = err_inc;
                        res_ev   = EV_OVERFLOW;
                        res_line = cur_line;
                        res_top  = code_char(r_top);
                        res_cur  = i_ch;
                    end else begin
                        n_sp    = r_sp + SPW'(1);
                        n_top   = op_code;
                        o_wr_en = 1'b1;
                    end
                end else if (op_close) begin
                    if (sp_empty) begin
                        n_err    = err_inc;
                        res_err  = err_inc;
                        res_ev   = EV_EMPTY;
                        res_line = cur_line;
                        res_cur  = i_ch;
                    end else if (r_top != op_code) begin
                        n_err    = err_inc;
                        res_err  = err_inc;
                        res_ev   = EV_MISMATCH;
                        res_line = cur_line;
                        res_top  = code_char(r_top);
                        res_cur  = i_ch;
                    end else begin
                        n_sp  = r_sp - SPW'(1);
                        n_top = i_next_code;
                    end
                end
            end
            REQ_EOL: begin
                n_sp   = eol_sp;
                n_top  = eol_top;
                n_dq   = 1'b0;
                n_sq   = 1'b0;
                n_seen = r_seen | ~r_has;
                n_line = cur_line;
                n_has  = 1'b0;
            end
            REQ_EOI: begin
                res_cur = CH_END_MARK;
                if (r_err == '0 && eol_sp == '0) begin
                    res_ev = EV_CORRECT;
                end else if (eol_sp != '0) begin
                    res_ev   = EV_UNCLOSED;
                    res_line = r_has ? r_line + LINE_BITS'(2) : cur_line;
                    res_top  = code_char(eol_top);
                end
                // stream closed, back to the reset state
                n_sp   = '0;
                n_dq   = 1'b0;
                n_sq   = 1'b0;
                n_line = '0;
                n_err  = '0;
                n_seen = 1'b0;
                n_has  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_dq   <= 1'b0;
            r_sq   <= 1'b0;
            r_line <= '0;
            r_err  <= '0;
            r_seen <= 1'b0;
            r_has  <= 1'b0;
        end else if (i_accept) begin
            r_sp   <= n_sp;
            r_dq   <= n_dq;
            r_sq   <= n_sq;
            r_line <= n_line;
            r_err  <= n_err;
            r_seen <= n_seen;
            r_has  <= n_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_top <= n_top;
        end
    end

    // prefetch the two entries under the next top
    assign addr_sp     = i_accept ? n_sp : r_sp;
    assign rd_a_full   = addr_sp - SPW'(2);
    assign rd_b_full   = addr_sp - SPW'(3);
    assign o_rd_addr_a = rd_a_full[IDXW-1:0];
    assign o_rd_addr_b = rd_b_full[IDXW-1:0];
    assign o_wr_addr   = r_sp[IDXW-1:0];
    assign o_wr_code   = op_code;

    assign line_ext = {{OUT_LINE_W{1'b0}}, res_line};

    assign o_result = '{
        ev_res:       res_ev,
        line_number:  line_ext[OUT_LINE_W-1:0],
        top_char:     res_top,
        current_char: res_cur,
        error_total:  res_err
    };

endmodule

`default_nettype wire

@@ rtl/core/bracket_quote_balance_checker.sv @@
// ----------------------------------------------------------------------------
// bracket_quote_balance_checker
// Checks nesting of (), [], {} and per-line quote pairs in a character stream.
//
// Input channel: i_in_valid / o_in_stall carry one request (i_req_type,
// i_ch): a character, an end of line or an end of input.
// Output channel: o_out_valid / i_out_stall carry exactly one result per
// request, in request order: event code, line number, stack top, offending
// character and running error count.
// The result is registered and appears in the cycle after the request
// is taken. Throughput: one request per cycle unless i_out_stall holds a
// result; the stack top sits in a register and the two entries beneath it
// are prefetched from the stack memory over its two read ports, so pushes,
// pops and end of line double drops follow each other without a gap.
// Stall: while a result waits under i_out_stall, o_in_stall is raised and no
// request is taken; the waiting result holds.
// Reset (synchronous, active low): stack empty, counters and parities clear,
// no result pending. Stack memory contents are left as they are. An end of
// input request also clears the stack, counters and parities.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_quote_balance_checker
    import bqbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [REQ_W-1:0]       i_req_type,
    input  wire  [CHAR_W-1:0]      i_ch,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [EV_W-1:0]        o_event_res,
    output logic [OUT_LINE_W-1:0]  o_line_number,
    output logic [CHAR_W-1:0]      o_top_char,
    output logic [CHAR_W-1:0]      o_current_char,
    output logic [ERR_W-1:0]       o_error_total
);

    localparam int IDXW = $clog2(STACK_DEPTH);

    logic            accept;
    logic            wr_en;
    logic [IDXW-1:0] wr_addr;
    t_code           wr_code;
    logic [IDXW-1:0] rd_addr_a;
    logic [IDXW-1:0] rd_addr_b;
    t_code           rd_code_a;
    t_code           rd_code_b;
    t_result         result;

    logic            r_out_valid;
    t_result         r_out;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    bqbc_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en & accept),
        .i_wr_addr   (wr_addr),
        .i_wr_code   (wr_code),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_code_a (rd_code_a),
        .o_rd_code_b (rd_code_b)
    );

    bqbc_engine #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_ch         (i_ch),
        .i_next_code  (rd_code_a),
        .i_third_code (rd_code_b),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_code    (wr_code),
        .o_rd_addr_a  (rd_addr_a),
        .o_rd_addr_b  (rd_addr_b),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_out.ev_res;
    assign o_line_number  = r_out.line_number;
    assign o_top_char     = r_out.top_char;
    assign o_current_char = r_out.current_char;
    assign o_error_total  = r_out.error_total;

endmodule

`default_nettype wire

@@ verif/balance_result_checker.sv @@
// ----------------------------------------------------------------------------
// balance_result_checker
// Watches both channels of the bracket and quote balance checker, keeps its
// own model of the bracket stack, quote parities and line counting, and
// compares every result against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module balance_result_checker
    import bqbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_req_valid,
    input  wire                   i_req_stall,
    input  wire  [REQ_W-1:0]      i_req_type,
    input  wire  [CHAR_W-1:0]     i_req_char,
    input  wire                   i_res_valid,
    input  wire                   i_res_stall,
    input  wire  [EV_W-1:0]       i_res_event,
    input  wire  [OUT_LINE_W-1:0] i_res_line,
    input  wire  [CHAR_W-1:0]     i_res_top,
    input  wire  [CHAR_W-1:0]     i_res_char,
    input  wire  [ERR_W-1:0]      i_res_total,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_flagged,
    output int                    o_overflows
);

    t_char                 open_stack [STACK_DEPTH];
    int                    depth;
    bit                    dq_open;
    bit                    sq_open;
    logic [OUT_LINE_W-1:0] lines_done;
    logic [ERR_W-1:0]      err_tally;
    bit                    had_empty_line;
    bit                    line_busy;

    t_result               pending_reports [$];
    t_result               want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_flagged    = 0;
        o_overflows  = 0;
    end

    function automatic void clear_model();
        depth          = 0;
        dq_open        = 1'b0;
        sq_open        = 1'b0;
        lines_done     = '0;
        err_tally      = '0;
        had_empty_line = 1'b0;
        line_busy      = 1'b0;
    endfunction

    function automatic t_char stack_top();
        return (depth == 0) ? t_char'(0) : open_stack[depth-1];
    endfunction

    function automatic void count_error();
        if (err_tally != '1) begin
            err_tally++;
        end
    endfunction

    function automatic t_result make_report(t_ev ev, logic [OUT_LINE_W-1:0] line,
                                            t_char top, t_char cur);
        t_result r;
        r.ev_res       = ev;
        r.line_number  = line;
        r.top_char     = top;
        r.current_char = cur;
        r.error_total  = err_tally;
        return r;
    endfunction

    function automatic void push_opener(t_char c, inout t_result r);
        if (depth >= STACK_DEPTH) begin
            count_error();
            r = make_report(EV_OVERFLOW, lines_done + 1'b1, stack_top(), c);
        end else begin
            open_stack[depth] = c;
            depth++;
        end
    endfunction

    function automatic void match_closer(t_char opener, t_char c, inout t_result r);
        if (depth == 0) begin
            count_error();
            r = make_report(EV_EMPTY, lines_done + 1'b1, 8'd0, c);
        end else if (stack_top() != opener) begin
            count_error();
            r = make_report(EV_MISMATCH, lines_done + 1'b1, stack_top(), c);
        end else begin
            depth--;
        end
    endfunction

    // dangling quotes are dropped, double quote first
    function automatic void close_line();
        if (dq_open && stack_top() == CH_DQUOTE) begin
            depth--;
        end
        if (sq_open && stack_top() == CH_SQUOTE) begin
            depth--;
        end
        dq_open = 1'b0;
        sq_open = 1'b0;
        if (!line_busy) begin
            had_empty_line = 1'b1;
        end
        lines_done++;
    endfunction

    function automatic t_result predict_balance_event(t_req kind, t_char c);
        t_result r;
        bit      last_busy;
        r = make_report(EV_NONE, '0, 8'd0, 8'd0);
        case (kind)
            REQ_CHAR: begin
                line_busy = 1'b1;
                case (c)
                    CH_LPAREN, CH_LBRACK, CH_LBRACE: push_opener(c, r);
                    CH_RPAREN: match_closer(CH_LPAREN, c, r);
                    CH_RBRACK: match_closer(CH_LBRACK, c, r);
                    CH_RBRACE: match_closer(CH_LBRACE, c, r);
                    CH_DQUOTE: begin
                        dq_open = !dq_open;
                        if (dq_open) push_opener(c, r);
                        else match_closer(CH_DQUOTE, c, r);
                    end
                    CH_SQUOTE: begin
                        sq_open = !sq_open;
                        if (sq_open) push_opener(c, r);
                        else match_closer(CH_SQUOTE, c, r);
                    end
                    default: ;
                endcase
            end
            REQ_EOL: begin
                close_line();
                line_busy = 1'b0;
            end
            REQ_EOI: begin
                last_busy = line_busy;
                close_line();
                if (err_tally == '0 && depth == 0) begin
                    r = make_report(EV_CORRECT, '0, 8'd0, CH_END_MARK);
                end else if (depth != 0) begin
                    r = make_report(EV_UNCLOSED,
                                    (!had_empty_line || last_busy) ? lines_done + 1'b1
                                                                   : lines_done,
                                    stack_top(), CH_END_MARK);
                end else begin
                    r = make_report(EV_NONE, '0, 8'd0, CH_END_MARK);
                end
                clear_model();
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void compare_field(string name, int unsigned exp_val,
                                          int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            pending_reports.delete();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                pending_reports.push_back(predict_balance_event(i_req_type, i_req_char));
            end
            if (i_res_valid && !i_res_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("result with no request outstanding: event_res %0d", i_res_event);
                    o_fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    compare_field("event_res",    want.ev_res,       i_res_event);
                    compare_field("line_number",  want.line_number,  i_res_line);
                    compare_field("top_char",     want.top_char,     i_res_top);
                    compare_field("current_char", want.current_char, i_res_char);
                    compare_field("error_total",  want.error_total,  i_res_total);
                    o_checked++;
                    if (want.ev_res != EV_NONE) begin
                        o_flagged++;
                    end
                    if (want.ev_res == EV_OVERFLOW) begin
                        o_overflows++;
                    end
                end
            end
        end
        o_pending = pending_reports.size();
    end

endmodule

`default_nettype wire

@@ verif/bracket_quote_balance_checker_test.sv @@
// ----------------------------------------------------------------------------
// bracket_quote_balance_checker_test
// Drives character, end of line and end of input requests into the balance
// checker: a directed opening, then random documents that are mostly well
// nested, with deep nesting to reach stack overflow, under random gaps and
// result stalls. Checking is done by balance_result_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_quote_balance_checker_test;

    import bqbc_pkg::*;

    localparam int   STACK_DEPTH    = 64;
    localparam int   RANDOM_ITEMS   = 750;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam t_req REQ_UNDEF      = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    t_req                  req_type  = REQ_CHAR;
    t_char                 req_char  = '0;
    logic                  res_stall = 1'b0;
    wire                   req_stall;
    wire                   res_valid;
    wire  [EV_W-1:0]       res_event;
    wire  [OUT_LINE_W-1:0] res_line;
    wire  [CHAR_W-1:0]     res_top;
    wire  [CHAR_W-1:0]     res_char;
    wire  [ERR_W-1:0]      res_total;

    int fail_count;
    int pending;
    int checked;
    int flagged;
    int overflows;

    int sent        = 0;
    int documents   = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit idle_in     = 1'b1;
    bit quiet_out   = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bracket_quote_balance_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_stall     (req_stall),
        .i_req_type     (req_type),
        .i_ch           (req_char),
        .o_out_valid    (res_valid),
        .i_out_stall    (res_stall),
        .o_event_res    (res_event),
        .o_line_number  (res_line),
        .o_top_char     (res_top),
        .o_current_char (res_char),
        .o_error_total  (res_total)
    );

    balance_result_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) results_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req_type   (req_type),
        .i_req_char   (req_char),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_res_event  (res_event),
        .i_res_line   (res_line),
        .i_res_top    (res_top),
        .i_res_char   (res_char),
        .i_res_total  (res_total),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_flagged    (flagged),
        .o_overflows  (overflows)
    );

    // result back-pressure: mostly short holds, now and then a long one
    always @(posedge clk) begin
        if (stall_left > 0) begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (quiet_out || $urandom_range(99) < 70) begin
            res_stall <= 1'b0;
        end else begin
            res_stall  <= 1'b1;
            stall_left <= ($urandom_range(19) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(0, 2);
        end
    end

    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_char pick_opener();
        case ($urandom_range(2))
            0:       return CH_LPAREN;
            1:       return CH_LBRACK;
            default: return CH_LBRACE;
        endcase
    endfunction

    function automatic t_char closer_for(t_char opener);
        case (opener)
            CH_LPAREN: return CH_RPAREN;
            CH_LBRACK: return CH_RBRACK;
            default:   return CH_RBRACE;
        endcase
    endfunction

    task automatic send_request(t_req kind, t_char c);
        int gap;
        gap = idle_in ? pick_gap() : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        req_char  <= c;
        do @(posedge clk); while (req_stall);
        if (kind != REQ_UNDEF) begin
            sent++;
        end
    endtask

    task automatic send_char(t_char c);
        send_request(REQ_CHAR, c);
    endtask

    task automatic send_eol();
        send_request(REQ_EOL, t_char'($urandom_range(255)));
    endtask

    task automatic send_eoi();
        send_request(REQ_EOI, t_char'($urandom_range(255)));
        documents++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic quoted_text();
        t_char q;
        int    len;
        q   = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        len = $urandom_range(0, 3);
        send_char(q);
        repeat (len) send_char(t_char'($urandom_range(97, 122)));
        if ($urandom_range(4) != 0) begin
            send_char(q);
        end
    endtask

    task automatic plain_document();
        t_char opens [$];
        int    n_lines;
        int    len;
        int    r;
        t_char c;
        n_lines = $urandom_range(1, 6);
        repeat (n_lines) begin
            len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
            repeat (len) begin
                r = $urandom_range(99);
                if (r < 30) begin
                    c = pick_opener();
                    send_char(c);
                    opens.push_back(c);
                end else if (r < 60 && opens.size() > 0) begin
                    send_char(closer_for(opens.pop_back()));
                end else if (r < 70) begin
                    quoted_text();
                end else if (r < 88) begin
                    send_char(t_char'($urandom_range(97, 122)));
                end else if (r < 97) begin
                    send_char(t_char'($urandom_range(255)));
                end else begin
                    send_request(REQ_UNDEF, t_char'($urandom_range(255)));
                end
            end
            send_eol();
        end
        if ($urandom_range(4) != 0) begin
            while (opens.size() > 0) send_char(closer_for(opens.pop_back()));
            if ($urandom_range(1)) send_eol();
        end
        if ($urandom_range(3) == 0) begin
            send_eol();
        end
        send_eoi();
    endtask

    // nest n deep, past the stack depth when n reaches it, then unwind what was kept
    task automatic deep_document(int n);
        t_char opens [$];
        t_char c;
        t_char q;
        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        repeat (n) begin
            c = pick_opener();
            send_char(c);
            if (opens.size() < STACK_DEPTH) opens.push_back(c);
        end
        if (n >= STACK_DEPTH) send_char(q);
        while (opens.size() > 0) send_char(closer_for(opens.pop_back()));
        if (n >= STACK_DEPTH) send_char(q);
        send_eol();
        send_eoi();
    endtask

    initial begin
        int random_start;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nested brackets, quotes and extreme bytes, then a clean end
        send_char(CH_LPAREN);
        send_char(CH_LBRACK);
        send_char(CH_LBRACE);
        send_char(CH_RBRACE);
        send_char(CH_RBRACK);
        send_char(CH_RPAREN);
        send_eol();
        send_char(CH_DQUOTE);
        send_char(8'h00);
        send_char(8'hff);
        send_char(CH_DQUOTE);
        send_eoi();
        // an empty line then an unclosed bracket
        send_eol();
        send_char(CH_LPAREN);
        send_eol();
        send_eoi();
        // close on empty, mismatch, dangling quote, unknown request
        send_char(CH_RPAREN);
        send_char(CH_LPAREN);
        send_char(CH_RBRACK);
        send_char(CH_SQUOTE);
        send_eol();
        send_request(REQ_UNDEF, 8'h5a);
        send_eoi();
        // errors with an empty stack at the end
        send_char(CH_RBRACE);
        send_eoi();
        drain_results();

        random_start = sent;
        deep_document(STACK_DEPTH + 2);
        while (sent - random_start < RANDOM_ITEMS) begin
            idle_in   = ($urandom_range(3) != 0);
            quiet_out = ($urandom_range(3) == 0);
            if ($urandom_range(9) == 0) begin
                deep_document($urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 6));
            end else begin
                plain_document();
            end
            if ($urandom_range(5) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        $display("%0d requests in %0d documents, %0d results checked", sent, documents,
                 checked);
        $display("%0d events flagged, %0d of them stack overflows", flagged, overflows);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/bqbc_pkg.sv
rtl/core/bqbc_stack_mem.sv
rtl/core/bqbc_engine.sv
rtl/core/bracket_quote_balance_checker.sv
verif/balance_result_checker.sv
verif/bracket_quote_balance_checker_test.sv
